@@ hdl/mrc_pkg.sv @@
// shared types, constants and helper functions for the multiply-rotate-counter generator
`default_nettype none

package mrc_pkg;

  // width mode codes
  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_32 = 2'd1;
  localparam logic [1:0] MODE_64 = 2'd2;

  // item kind codes
  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

  // multiplier constants per width
  localparam logic [63:0] K64 = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [31:0] K32 = 32'h7f4a_7c15;
  localparam logic [31:0] K16 = 32'h0000_a965;

  // rotate amounts per width
  localparam int unsigned S64 = 21;
  localparam int unsigned S32 = 19;
  localparam int unsigned S16 = 10;

  // discarded steps after a seed per width
  localparam logic [3:0] WARM64 = 4'd6;
  localparam logic [3:0] WARM32 = 4'd7;
  localparam logic [3:0] WARM16 = 4'd9;

  // request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } mul_req_t;

  // low bits mask of the active width
  function automatic logic [63:0] width_mask(input logic [1:0] mode);
    logic [63:0] m;
    unique case (mode)
      MODE_16: m = 64'h0000_0000_0000_ffff;
      MODE_32: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // low multiplier constant word for the first partial product
  function automatic logic [31:0] k_low(input logic [1:0] mode);
    logic [31:0] k;
    unique case (mode)
      MODE_16: k = K16;
      MODE_32: k = K32;
      default: k = K64[31:0];
    endcase
    return k;
  endfunction

  // number of warm-up steps after a seed
  function automatic logic [3:0] warm_count(input logic [1:0] mode);
    logic [3:0] n;
    unique case (mode)
      MODE_16: n = WARM16;
      MODE_32: n = WARM32;
      default: n = WARM64;
    endcase
    return n;
  endfunction

  // rotate left at the active width, result zero-extended
  function automatic logic [63:0] rotl_w(input logic [63:0] x, input logic [1:0] mode);
    logic [15:0] x16;
    logic [31:0] x32;
    logic [63:0] r;
    x16 = x[15:0];
    x32 = x[31:0];
    unique case (mode)
      MODE_16: r = {48'd0, (x16 << S16) | (x16 >> (16 - S16))};
      MODE_32: r = {32'd0, (x32 << S32) | (x32 >> (32 - S32))};
      default: r = (x << S64) | (x >> (64 - S64));
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mrc_in_if.sv @@
// input channel: seed or next items
`default_nettype none

interface mrc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] seed_lo;
  logic [63:0] seed_hi;

  modport source (output valid, kind, seed_lo, seed_hi, input ready);
  modport sink   (input valid, kind, seed_lo, seed_hi, output ready);
endinterface

`default_nettype wire

@@ hdl/mrc_out_if.sv @@
// output channel: generated random words
`default_nettype none

interface mrc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface

`default_nettype wire

@@ hdl/mrc_mul_unit.sv @@
// shared 32x32 multiplier with registered product
`default_nettype none

module mrc_mul_unit (
  input  wire logic              clk_i,
  input  wire mrc_pkg::mul_req_t req_i,
  output logic [63:0]            prod_o
);
  import mrc_pkg::*;

  logic [63:0] prod_q;

  // full product of the two 32 bit operands
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= {32'd0, req_i.op_a} * {32'd0, req_i.op_b};
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ hdl/multiply_rotate_counter_prng.sv @@
// multiply-rotate-counter generator, top level with step sequencer
// next item at 64 bit: result registered through states MUL0, MUL1, MUL2, ACC and FIN
//   (3 multiplier passes); at 16 or 32 bit through MUL0, MUL1 and FIN; next accept in IDLE.
// seed item: load, then 6 unemitted steps (64 bit), 7 (32), 9 (16).
// the shared 32x32 multiplier sets the step length; the result register frees the input early.
// reset (async, active low): words and counter zero, width mode 64 bit, no result pending.
`default_nettype none

module multiply_rotate_counter_prng (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  mrc_in_if.sink          req_i,
  mrc_out_if.source       rsp_o
);
  import mrc_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [1:0]  mode_q;
  logic [2:0]  state_q, state_d;
  logic [63:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic [63:0] anew_q, anew_d, acc_q, acc_d;
  logic [3:0]  left_q, left_d;
  logic        emit_q, emit_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_word_q, out_word_d;

  mul_req_t    mul_req;
  logic [63:0] mul_p;

  logic [63:0] mask, a_m, b_m, c_m, old_w, rot_b, result_w;
  logic        is64, fin_go;

  mrc_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  // width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_64;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // words reduced to the active width
  assign mask     = width_mask(mode_q);
  assign is64     = (mode_q != MODE_16) && (mode_q != MODE_32);
  assign a_m      = a_q & mask;
  assign b_m      = b_q & mask;
  assign c_m      = c_q & mask;
  assign old_w    = acc_q & mask;
  assign rot_b    = rotl_w(b_m, mode_q);
  assign result_w = (old_w + anew_q) & mask;
  assign fin_go   = !emit_q || !out_valid_q || rsp_o.ready;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = out_word_q;

  // step sequencer
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    anew_d      = anew_q;
    acc_d       = acc_q;
    left_d      = left_q;
    emit_d      = emit_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    mul_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_MUL0;
          if (req_i.kind == KIND_SEED) begin
            left_d = warm_count(mode_q);
            emit_d = 1'b0;
            unique case (mode_q)
              MODE_16: begin
                a_d = {48'd0, req_i.seed_lo[15:0]};
                b_d = {48'd0, req_i.seed_lo[31:16]};
                c_d = {48'd0, req_i.seed_lo[47:32]};
              end
              MODE_32: begin
                a_d = {32'd0, req_i.seed_lo[31:0]};
                b_d = {32'd0, req_i.seed_lo[63:32]};
                c_d = 64'd1;
              end
              default: begin
                a_d = req_i.seed_lo;
                b_d = req_i.seed_hi;
                c_d = 64'd1;
              end
            endcase
          end else begin
            left_d = 4'd1;
            emit_d = 1'b1;
          end
        end
      end
      ST_MUL0: begin
        mul_req = '{en: 1'b1, op_a: a_m[31:0], op_b: k_low(mode_q)};
        anew_d  = (b_m + c_m) & mask;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d = mul_p;
        if (is64) begin
          mul_req = '{en: 1'b1, op_a: a_m[63:32], op_b: K64[31:0]};
          state_d = ST_MUL2;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL2: begin
        acc_d   = acc_q + {mul_p[31:0], 32'd0};
        mul_req = '{en: 1'b1, op_a: a_m[31:0], op_b: K64[63:32]};
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q + {mul_p[31:0], 32'd0};
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // wait here only if a result is due and the output register is still full
        if (fin_go) begin
          a_d = anew_q;
          b_d = rot_b ^ old_w;
          c_d = (c_m + 64'd1) & mask;
          if (emit_q) begin
            out_valid_d = 1'b1;
            out_word_d  = result_w;
          end
          if (left_q == 4'd1) begin
            state_d = ST_IDLE;
          end else begin
            left_d  = left_q - 4'd1;
            state_d = ST_MUL0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      left_q      <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_q         <= a_d;
      b_q         <= b_d;
      c_q         <= c_d;
      left_q      <= left_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    anew_q     <= anew_d;
    acc_q      <= acc_d;
    out_word_q <= out_word_d;
  end

endmodule

`default_nettype wire

@@ test/multiply_rotate_counter_prng_tb.sv @@
// testbench for the multiply-rotate-counter generator: predicted words checked in order
`default_nettype none

module multiply_rotate_counter_prng_tb;
  import mrc_pkg::*;

  // unused width code, the block treats it as 64 bit
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // settle time after a drain, with margin over the longest seed warm-up
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned NUM_PHASES = 7;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_style_e;

  // generator state tracker and expected word store
  class prng_tracker;
    logic [1:0]  mode;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] step_count;
    logic [63:0] expected_words[$];
    int unsigned errors;
    int unsigned words_checked;

    function new();
      mode = MODE_64;
      word_a = '0;
      word_b = '0;
      step_count = '0;
      errors = 0;
      words_checked = 0;
    endfunction

    // one generator step at the current width
    function logic [63:0] advance_state();
      logic [63:0] m;
      logic [63:0] k;
      logic [63:0] old;
      logic [63:0] rot;
      int unsigned w;
      int unsigned s;
      case (mode)
        MODE_16: begin
          w = 16;
          k = 64'(K16);
          s = S16;
        end
        MODE_32: begin
          w = 32;
          k = 64'(K32);
          s = S32;
        end
        default: begin
          w = 64;
          k = K64;
          s = S64;
        end
      endcase
      m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      word_a &= m;
      word_b &= m;
      step_count &= m;
      old = (word_a * k) & m;
      rot = ((word_b << s) | (word_b >> (w - s))) & m;
      word_a = (word_b + step_count) & m;
      step_count = (step_count + 64'd1) & m;
      word_b = rot ^ old;
      return (old + word_a) & m;
    endfunction

    // accepted input item: seed loads and warms up, next yields one word
    function void note_item(logic kind, logic [63:0] lo, logic [63:0] hi);
      int unsigned warm;
      if (kind == KIND_NEXT) begin
        expected_words.push_back(advance_state());
      end else begin
        case (mode)
          MODE_16: begin
            word_a = 64'(lo[15:0]);
            word_b = 64'(lo[31:16]);
            step_count = 64'(lo[47:32]);
            warm = 32'(WARM16);
          end
          MODE_32: begin
            word_a = 64'(lo[31:0]);
            word_b = 64'(lo[63:32]);
            step_count = 64'd1;
            warm = 32'(WARM32);
          end
          default: begin
            word_a = lo;
            word_b = hi;
            step_count = 64'd1;
            warm = 32'(WARM64);
          end
        endcase
        repeat (warm) void'(advance_state());
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one output word with the oldest prediction
    task check_word(logic [63:0] got);
      logic [63:0] want;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h with nothing expected", got));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got !== want)
          report($sformatf("random_word got %h want %h", got, want));
      end
    endtask

    task flush_leftovers();
      while (expected_words.size() != 0)
        report($sformatf("word %h never arrived", expected_words.pop_front()));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  mrc_in_if  req_if ();
  mrc_out_if rsp_if ();

  prng_tracker tracker = new();

  int unsigned cycles;
  int unsigned seeds_seen;
  int unsigned nexts_seen;
  int unsigned settings_used;
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned seg_left;
  rx_style_e   rx_style;
  int unsigned burst_left;
  bit          no_gaps;

  multiply_rotate_counter_prng i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // handshake monitor: predict on accepted items, check accepted words
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        tracker.note_item(req_if.kind, req_if.seed_lo, req_if.seed_hi);
        if (req_if.kind == KIND_SEED) seeds_seen++;
        else nexts_seen++;
      end
      if (rsp_if.valid && rsp_if.ready)
        tracker.check_word(rsp_if.random_word);
    end
  end

  // receiver: long hold on request, else stall styles in random segments
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        seg_left = $urandom_range(8, 120);
      end
      seg_left--;
      case (rx_style)
        RX_ALWAYS:      rsp_if.ready <= 1'b1;
        RX_COIN:        rsp_if.ready <= 1'($urandom_range(0, 1));
        RX_ONE_IN_FOUR: rsp_if.ready <= (seg_left % 4 == 0);
        default:        rsp_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(logic kind, logic [63:0] lo, logic [63:0] hi);
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.seed_lo <= lo;
    req_if.seed_hi <= hi;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // sender bursts with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // wait until every predicted word is out and the block is idle
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(logic [1:0] mode);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.mode = mode;
    settings_used++;
  endtask

  function automatic logic [63:0] random_seed_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_item();
    logic kind;
    kind = ($urandom_range(0, 99) < 12) ? KIND_SEED : KIND_NEXT;
    pace_sender();
    send_item(kind, random_seed_word(), random_seed_word());
  endtask

  // stimulus
  initial begin
    logic [1:0] phase_modes [NUM_PHASES];
    phase_modes = '{MODE_16, MODE_32, MODE_64, MODE_SPARE, MODE_16, MODE_32, MODE_64};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_NEXT;
    req_if.seed_lo = '0;
    req_if.seed_hi = '0;
    rsp_if.ready = 1'b0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // next before any seed, then seed extremes at 64 bit
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_NEXT, '1, '1);
    send_item(KIND_SEED, '0, '0);
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_SEED, '1, '1);
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_SEED, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(KIND_NEXT, '0, '0);

    // 32 bit, the high seed word must be ignored
    set_width(MODE_32);
    send_item(KIND_SEED, 64'h8000_0001_ffff_0000, '1);
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_NEXT, '0, '0);

    // 16 bit, counter seeded at its top so it wraps
    set_width(MODE_16);
    send_item(KIND_SEED, 64'hffff_ffff_1234_abcd, '1);
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_NEXT, '0, '0);

    // width changes between items without a new seed
    set_width(MODE_64);
    send_item(KIND_NEXT, '0, '0);
    set_width(MODE_16);
    send_item(KIND_NEXT, '0, '0);

    // unused width code
    set_width(MODE_SPARE);
    send_item(KIND_SEED, '1, 64'h0123_4567_89ab_cdef);
    send_item(KIND_NEXT, '0, '0);

    // random phases over all width settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_width(phase_modes[p]);
      no_gaps = (p == 2);
      burst_left = 0;
      if (p == 4) begin
        // long receiver hold while the sender keeps pushing
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 40; i++) send_item(KIND_NEXT, '0, '0);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
    end

    // wind down
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.flush_leftovers();
    $display("run covered %0d seed items and %0d next items over %0d width settings",
             seeds_seen, nexts_seen, settings_used);
    $display("%0d output words compared, %0d mismatches", tracker.words_checked,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ multiply_rotate_counter_prng.f @@
hdl/mrc_pkg.sv
hdl/mrc_in_if.sv
hdl/mrc_out_if.sv
hdl/mrc_mul_unit.sv
hdl/multiply_rotate_counter_prng.sv
test/multiply_rotate_counter_prng_tb.sv
